>>> design/pfgl_pkg.sv
package pfgl_pkg;

	localparam int IN_W              = 16;
	localparam int ID_W              = 2;
	localparam int PRIME_OUT_W       = 16;
	localparam int EXP_OUT_W         = 5;
	localparam int PROD_W            = 32;
	localparam int S_DATA_W          = 32;
	localparam int M_DATA_W          = 56;
	localparam int RESULT_LIMIT      = 34;
	localparam int K_W               = 6;
	localparam int DEF_OPERAND_WIDTH = 16;
	localparam int DEF_MAX_PRIMES    = 8;

	localparam logic [ID_W-1:0] LIST_A   = 2'd0;
	localparam logic [ID_W-1:0] LIST_B   = 2'd1;
	localparam logic [ID_W-1:0] LIST_GCD = 2'd2;
	localparam logic [ID_W-1:0] LIST_LCM = 2'd3;

endpackage

>>> design/prime_factor_gcd_lcm_core.sv
// Factoring: each operand is divided by trial divisors counting up from 2, while the
// divisor's square does not exceed the remaining value, in the shared bit-serial divider,
// one pass per trial divisor and per exact division; the list products are then built in
// the multiplier, one multiply per exponent unit. One request at a time: s_tready is high
// only between requests, so a new request is taken only once the previous one is finished.
// Reset: arst_n clears the sequencer, counters and output valid asynchronously.
module prime_factor_gcd_lcm_core
	import pfgl_pkg::*;
#(
	parameter int OPERAND_WIDTH = DEF_OPERAND_WIDTH,
	parameter int MAX_PRIMES    = DEF_MAX_PRIMES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // operand_a[15:0], operand_b[31:16]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // list_id, prime, exponent, product, zero pad
	output logic                m_tlast
);

	localparam int W     = OPERAND_WIDTH;
	localparam int IDX_W = $clog2(MAX_PRIMES);
	localparam int CNT_W = $clog2(MAX_PRIMES + 1);
	localparam int EXP_W = $clog2(W + 1);
	localparam int SQ_W  = W + 2;
	localparam int DC_W  = $clog2(W);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_CHK  = 5'b00010,
		S_DIV  = 5'b00100,
		S_SEL  = 5'b01000,
		S_MUL  = 5'b10000
	} state_t;

	state_t state_q;

	logic [W-1:0]     ap_q [MAX_PRIMES];
	logic [EXP_W-1:0] ae_q [MAX_PRIMES];
	logic [W-1:0]     bp_q [MAX_PRIMES];
	logic [EXP_W-1:0] be_q [MAX_PRIMES];
	logic [CNT_W-1:0] a_cnt_q, b_cnt_q;

	logic             op_q;
	logic [W-1:0]     bhold_q, n_q, d_q, quo_q;
	logic [W:0]       rem_q;
	logic [SQ_W-1:0]  sq_q;
	logic [EXP_W-1:0] e_q;
	logic [DC_W-1:0]  dc_q;

	logic [ID_W-1:0]  lid_q;
	logic [CNT_W-1:0] ia_q, ib_q;
	logic [PROD_W-1:0] prod_q;
	logic [W-1:0]     mulp_q;
	logic [EXP_W-1:0] mulc_q;
	logic [K_W-1:0]   k_q;

	logic              ov_q, ol_q;
	logic [ID_W-1:0]   oid_q;
	logic [PRIME_OUT_W-1:0] op16_q;
	logic [EXP_OUT_W-1:0]   oe_q;
	logic [PROD_W-1:0] oprod_q;

	logic [31:0] a32, b32;
	assign a32 = {{(32-IN_W){1'b0}}, s_tdata[IN_W-1:0]};
	assign b32 = {{(32-IN_W){1'b0}}, s_tdata[2*IN_W-1:IN_W]};

	// divider step
	logic [W:0]   rs, rdiff;
	logic         qbit;
	logic [W:0]   rem_nx;
	logic [W-1:0] quo_nx;
	always_comb begin
		rs     = {rem_q[W-1:0], quo_q[W-1]};
		rdiff  = rs - {1'b0, d_q};
		qbit   = (rs >= {1'b0, d_q});
		rem_nx = qbit ? rdiff : rs;
		quo_nx = {quo_q[W-2:0], qbit};
	end

	logic [CNT_W-1:0] cur_cnt;
	assign cur_cnt = op_q ? b_cnt_q : a_cnt_q;

	logic             wr_en;
	logic [W-1:0]     wr_p;
	logic [EXP_W-1:0] wr_e;
	always_comb begin
		wr_en = 1'b0;
		wr_p  = d_q;
		wr_e  = e_q;
		if (state_q == S_CHK && !(sq_q <= {2'b0, n_q})) begin
			wr_en = (n_q > W'(1)) && (cur_cnt < CNT_W'(MAX_PRIMES));
			wr_p  = n_q;
			wr_e  = EXP_W'(1);
		end else if (state_q == S_DIV && dc_q == DC_W'(W - 1) && rem_nx != '0) begin
			wr_en = (e_q != '0) && (cur_cnt < CNT_W'(MAX_PRIMES));
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (op_q) begin
				bp_q[cur_cnt[IDX_W-1:0]] <= wr_p;
				be_q[cur_cnt[IDX_W-1:0]] <= wr_e;
			end else begin
				ap_q[cur_cnt[IDX_W-1:0]] <= wr_p;
				ae_q[cur_cnt[IDX_W-1:0]] <= wr_e;
			end
		end
	end

	// list walk
	logic             a_ok, b_ok, eqp, take_a, done, emit;
	logic [W-1:0]     pa, pb, ent_p;
	logic [EXP_W-1:0] ea, eb, ent_e;
	logic             adv_a, adv_b;
	always_comb begin
		a_ok   = ia_q < a_cnt_q;
		b_ok   = ib_q < b_cnt_q;
		pa     = ap_q[ia_q[IDX_W-1:0]];
		ea     = ae_q[ia_q[IDX_W-1:0]];
		pb     = bp_q[ib_q[IDX_W-1:0]];
		eb     = be_q[ib_q[IDX_W-1:0]];
		eqp    = a_ok && b_ok && (pa == pb);
		take_a = !b_ok || (a_ok && pa < pb);
		done   = 1'b0;
		emit   = 1'b1;
		ent_p  = pa;
		ent_e  = ea;
		adv_a  = 1'b0;
		adv_b  = 1'b0;
		unique case (lid_q)
			LIST_A: begin
				done  = !a_ok;
				adv_a = 1'b1;
			end
			LIST_B: begin
				done  = !b_ok;
				ent_p = pb;
				ent_e = eb;
				adv_b = 1'b1;
			end
			default: begin
				done = !a_ok && !b_ok;
				if (eqp) begin
					ent_e = (lid_q == LIST_GCD) ? ((ea < eb) ? ea : eb) : ((ea < eb) ? eb : ea);
					adv_a = 1'b1;
					adv_b = 1'b1;
				end else if (take_a) begin
					emit  = (lid_q == LIST_LCM);
					adv_a = 1'b1;
				end else begin
					emit  = (lid_q == LIST_LCM);
					ent_p = pb;
					ent_e = eb;
					adv_b = 1'b1;
				end
			end
		endcase
	end

	logic need_out;
	assign need_out = done || emit;

	logic [31:0] ent_p32, mulp32;
	logic [63:0] mprod;
	assign ent_p32 = {{(32-W){1'b0}}, ent_p};
	assign mulp32  = {{(32-W){1'b0}}, mulp_q};
	assign mprod   = prod_q * mulp32;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
			a_cnt_q <= '0;
			b_cnt_q <= '0;
			k_q     <= '0;
		end else begin
			if (ov_q && m_tready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						n_q     <= a32[W-1:0];
						bhold_q <= b32[W-1:0];
						op_q    <= 1'b0;
						d_q     <= W'(2);
						sq_q    <= SQ_W'(4);
						e_q     <= '0;
						a_cnt_q <= '0;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (sq_q <= {2'b0, n_q}) begin
						quo_q   <= n_q;
						rem_q   <= '0;
						dc_q    <= '0;
						state_q <= S_DIV;
					end else begin
						if (wr_en) begin
							if (op_q) b_cnt_q <= b_cnt_q + 1'b1;
							else a_cnt_q <= a_cnt_q + 1'b1;
						end
						if (!op_q) begin
							op_q    <= 1'b1;
							n_q     <= bhold_q;
							d_q     <= W'(2);
							sq_q    <= SQ_W'(4);
							e_q     <= '0;
							b_cnt_q <= '0;
						end else begin
							lid_q   <= LIST_A;
							ia_q    <= '0;
							ib_q    <= '0;
							prod_q  <= PROD_W'(1);
							k_q     <= '0;
							state_q <= S_SEL;
						end
					end
				end
				S_DIV: begin
					if (dc_q == DC_W'(W - 1)) begin
						if (rem_nx == '0) begin
							n_q   <= quo_nx;
							quo_q <= quo_nx;
							rem_q <= '0;
							dc_q  <= '0;
							e_q   <= e_q + 1'b1;
						end else begin
							if (wr_en) begin
								if (op_q) b_cnt_q <= b_cnt_q + 1'b1;
								else a_cnt_q <= a_cnt_q + 1'b1;
							end
							d_q     <= d_q + 1'b1;
							sq_q    <= sq_q + {1'b0, d_q, 1'b0} + SQ_W'(1);
							e_q     <= '0;
							state_q <= S_CHK;
						end
					end else begin
						rem_q <= rem_nx;
						quo_q <= quo_nx;
						dc_q  <= dc_q + 1'b1;
					end
				end
				S_SEL: begin
					if (!(need_out && ov_q)) begin
						if (need_out) begin
							if (k_q < K_W'(RESULT_LIMIT)) begin
								ov_q <= 1'b1;
								k_q  <= k_q + 1'b1;
							end
							oid_q <= lid_q;
							if (done) begin
								op16_q  <= PRIME_OUT_W'(1);
								oe_q    <= '0;
								oprod_q <= prod_q;
								ol_q    <= (lid_q == LIST_LCM);
							end else begin
								op16_q  <= ent_p32[PRIME_OUT_W-1:0];
								oe_q    <= EXP_OUT_W'(ent_e);
								oprod_q <= '0;
								ol_q    <= 1'b0;
							end
						end
						if (done) begin
							if (lid_q == LIST_LCM) begin
								state_q <= S_IDLE;
							end else begin
								lid_q  <= lid_q + 1'b1;
								ia_q   <= '0;
								ib_q   <= '0;
								prod_q <= PROD_W'(1);
							end
						end else begin
							if (adv_a) ia_q <= ia_q + 1'b1;
							if (adv_b) ib_q <= ib_q + 1'b1;
							if (emit) begin
								mulp_q  <= ent_p;
								mulc_q  <= ent_e;
								state_q <= S_MUL;
							end
						end
					end
				end
				S_MUL: begin
					prod_q <= mprod[PROD_W-1:0];
					mulc_q <= mulc_q - 1'b1;
					if (mulc_q == EXP_W'(1)) begin
						state_q <= S_SEL;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = ov_q;
	assign m_tlast  = ol_q;
	assign m_tdata  = {1'b0, oprod_q, oe_q, op16_q, oid_q};

endmodule

>>> design/pfgl_checker.sv
module pfgl_checker
	import pfgl_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic [S_DATA_W-1:0] s_tdata,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic                m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready after accepting a request");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[1:0] == LIST_LCM && m_tdata[17:2] == 16'd1
			&& m_tdata[22:18] == 5'd0)
		else $error("last entry is not the LCM terminator");

	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[22:18] != 5'd0 |-> m_tdata[54:23] == 32'd0 && !m_tlast)
		else $error("factor entry carries a product or last flag");

endmodule

bind prime_factor_gcd_lcm_core pfgl_checker u_pfgl_checker (.*);
